// ===== design/packet_deframer_with_checksum_core_defines.svh =====
// Assertion helpers for the deframer. Clocked on clk, disabled in reset.
`ifndef PACKET_DEFRAMER_WITH_CHECKSUM_CORE_DEFINES_SVH
`define PACKET_DEFRAMER_WITH_CHECKSUM_CORE_DEFINES_SVH

// same-cycle implication
`define PDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pdc_pkg.sv =====
`default_nettype none

package pdc_pkg;

	localparam int unsigned MAX_PAYLOAD_DEFAULT = 128;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned INDEX_W    = 7;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAD      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ALT_HEAD  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAIL      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_END_FIRST = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_END_SECOND = 3'd4;

	// register reset values
	localparam logic [BYTE_W-1:0] HEAD_RST       = 8'hCC;
	localparam logic [BYTE_W-1:0] ALT_HEAD_RST   = 8'hFE;
	localparam logic [BYTE_W-1:0] TAIL_RST       = 8'hB9;
	localparam logic [BYTE_W-1:0] END_FIRST_RST  = 8'h0D;
	localparam logic [BYTE_W-1:0] END_SECOND_RST = 8'h0A;

	typedef struct packed {
		logic               payload_valid;
		logic [BYTE_W-1:0]  payload_byte;
		logic [INDEX_W-1:0] payload_index;
		logic               frame_done;
		logic [BYTE_W-1:0]  frame_id;
		logic [BYTE_W-1:0]  frame_length;
		logic [BYTE_W-1:0]  frame_checksum;
		logic               length_error;
	} result_t;

endpackage

`default_nettype wire

// ===== design/pdc_in_if.sv =====
`default_nettype none

interface pdc_in_if;
	logic                        valid;
	logic                        ready;
	logic [pdc_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/pdc_out_if.sv =====
`default_nettype none

interface pdc_out_if;
	logic             valid;
	logic             ready;
	pdc_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/packet_deframer_with_checksum_core.sv =====
// Channel  Dir  Word                                   Handshake
// rx       in   rx_byte, one received byte              valid/ready
// res      out  payload/frame/length_error result word  valid/ready
// cfg      in   cfg_index, cfg_data                      cfg_we, no stall
//
// One word in, one result word out, one word per clock sustained while res.ready is high.
// The only loop is the phase/counter/checksum update.
// The result is registered: the result register loads on the accepting edge.
// rx.ready is low only while a result sits unread and res.ready is low.
// arst_n clears phase, counters, sums and the configuration registers to their defaults.
`default_nettype none

`include "packet_deframer_with_checksum_core_defines.svh"

module packet_deframer_with_checksum_core #(
	parameter int unsigned MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pdc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	pdc_in_if.sink                               rx,
	pdc_out_if.source                            res
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_DATA,
		PH_TAIL,
		PH_SUM,
		PH_END1,
		PH_END2
	} phase_t;

	localparam logic [pdc_pkg::BYTE_W-1:0] MAX_LEN = pdc_pkg::BYTE_W'(MAX_PAYLOAD);

	// configuration registers
	logic [pdc_pkg::BYTE_W-1:0] head_q, alt_head_q, tail_q, end_first_q, end_second_q;

	// parser state
	phase_t                     phase_q, phase_d;
	logic [pdc_pkg::BYTE_W-1:0] byte_counter_q, byte_counter_d;
	logic [pdc_pkg::BYTE_W-1:0] running_sum_q, running_sum_d;
	logic [pdc_pkg::BYTE_W-1:0] stored_length_q, stored_length_d;
	logic [pdc_pkg::BYTE_W-1:0] stored_id_q, stored_id_d;

	// result register
	logic             res_valid_q;
	pdc_pkg::result_t res_payload_q;
	pdc_pkg::result_t res_d;

	logic                       accept;
	logic [pdc_pkg::BYTE_W-1:0] b;
	logic [pdc_pkg::BYTE_W-1:0] sum_upd;
	logic [pdc_pkg::BYTE_W-1:0] cnt_inc;

	// take a word whenever the result slot is free or being drained
	assign rx.ready = !res_valid_q || res.ready;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.rx_byte;

	// rotate right by one, then add
	assign sum_upd = {running_sum_q[0], running_sum_q[pdc_pkg::BYTE_W-1:1]} + b;
	assign cnt_inc = byte_counter_q + 8'd1;

	always_comb begin
		phase_d         = phase_q;
		byte_counter_d  = byte_counter_q;
		running_sum_d   = running_sum_q;
		stored_length_d = stored_length_q;
		stored_id_d     = stored_id_q;
		res_d           = '0;
		case (phase_q)
			PH_HUNT: begin
				// either head opens a frame; fresh counters so a dropped frame leaves no trace
				if (b == head_q || b == alt_head_q) begin
					byte_counter_d = '0;
					running_sum_d  = '0;
					stored_id_d    = '0;
					phase_d        = PH_LEN;
				end
			end
			PH_LEN: begin
				stored_length_d = b;
				if (b > MAX_LEN) begin
					res_d.length_error = 1'b1;
					phase_d            = PH_HUNT;
				end else if (b == '0) begin
					phase_d = PH_TAIL;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (byte_counter_q == '0)
					stored_id_d = b;
				res_d.payload_valid = 1'b1;
				res_d.payload_byte  = b;
				res_d.payload_index = byte_counter_q[pdc_pkg::INDEX_W-1:0];
				running_sum_d       = sum_upd;
				byte_counter_d      = cnt_inc;
				if (cnt_inc >= stored_length_q)
					phase_d = PH_TAIL;
			end
			PH_TAIL: begin
				if (b == tail_q)
					phase_d = PH_SUM;
			end
			PH_SUM: begin
				// mismatching bytes are skipped until one equals the sum
				if (b == running_sum_q)
					phase_d = PH_END1;
			end
			PH_END1: begin
				if (b == end_first_q)
					phase_d = PH_END2;
			end
			PH_END2: begin
				if (b == end_second_q) begin
					res_d.frame_done     = 1'b1;
					res_d.frame_id       = stored_id_q;
					res_d.frame_length   = stored_length_q;
					res_d.frame_checksum = running_sum_q;
					byte_counter_d       = '0;
					running_sum_d        = '0;
					phase_d              = PH_HUNT;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q          <= pdc_pkg::HEAD_RST;
			alt_head_q      <= pdc_pkg::ALT_HEAD_RST;
			tail_q          <= pdc_pkg::TAIL_RST;
			end_first_q     <= pdc_pkg::END_FIRST_RST;
			end_second_q    <= pdc_pkg::END_SECOND_RST;
			phase_q         <= PH_HUNT;
			byte_counter_q  <= '0;
			running_sum_q   <= '0;
			stored_length_q <= '0;
			stored_id_q     <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pdc_pkg::CFG_HEAD:       head_q       <= cfg_data;
					pdc_pkg::CFG_ALT_HEAD:   alt_head_q   <= cfg_data;
					pdc_pkg::CFG_TAIL:       tail_q       <= cfg_data;
					pdc_pkg::CFG_END_FIRST:  end_first_q  <= cfg_data;
					pdc_pkg::CFG_END_SECOND: end_second_q <= cfg_data;
					default: ; // unknown index: dropped
				endcase
			end
			if (accept) begin
				phase_q         <= phase_d;
				byte_counter_q  <= byte_counter_d;
				running_sum_q   <= running_sum_d;
				stored_length_q <= stored_length_d;
				stored_id_q     <= stored_id_d;
				res_valid_q     <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept)
			res_payload_q <= res_d;
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_payload_q;

	// a stalled result must block new words
	`PDC_ASSERT_NOW(a_stall_blocks_rx, res.valid && !res.ready, !rx.ready, "rx taken while result stalled")
	// a payload word in the data phase always yields a valid payload result
	`PDC_ASSERT_NEXT(a_data_gives_payload, accept && phase_q == PH_DATA, res.valid && res.payload.payload_valid, "data word without payload result")
	// result kinds are exclusive
	`PDC_ASSERT_NOW(a_kinds_exclusive, res.valid, !(res.payload.frame_done && res.payload.payload_valid) && !(res.payload.length_error && (res.payload.frame_done || res.payload.payload_valid)), "result flags overlap")
	// a length error always sends the parser back to the hunt
	`PDC_ASSERT_NEXT(a_len_err_hunts, accept && res_d.length_error, phase_q == PH_HUNT, "length error did not return to hunt")

endmodule

`default_nettype wire
